[rtl/core/scc_pkg.sv]
// ----------------------------------------------------------------------------
// Subset cover counter package
// Shared sizes, the sequencer state type and small helper functions.
// ----------------------------------------------------------------------------
package scc_pkg;

   localparam int MAX_SETS    = 32;
   localparam int HALF_SETS   = (MAX_SETS + 1) / 2;
   localparam int SET_IDX_W   = $clog2(MAX_SETS);
   localparam int SET_CNT_W   = $clog2(MAX_SETS + 1);
   localparam int HALF_CNT_W  = $clog2(HALF_SETS + 1);
   localparam int HALF_IDX_W  = (HALF_SETS > 1) ? $clog2(HALF_SETS) : 1;
   localparam int HALF_SZ_W   = HALF_SETS + 1;
   localparam int TAB_AW      = HALF_SETS + 1;
   localparam int TAB_DEPTH   = 2 ** TAB_AW;

   localparam int MASK_W      = 64;
   localparam int ID_W        = 6;
   localparam int COUNT_W     = 33;

   localparam int REQ_TDATA_W = ((ID_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = ((COUNT_W + 7) / 8) * 8;

   localparam int HAS_BIT     = 0;
   localparam int SET_END_BIT = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_BUILD_RD,
      ST_BUILD_WR,
      ST_A_RD,
      ST_A_CHECK,
      ST_B_SCAN,
      ST_B_DRAIN,
      ST_EMIT
   } state_type;

   // Elements 1..n as a mask; bit 0 is never part of it.
   function automatic logic [MASK_W-1:0] full_mask(input logic [ID_W-1:0] n);
      logic [MASK_W-1:0] full;
      full = '0;
      for (int b = 0; b < MASK_W; b++) begin
         full[b] = (b != 0) && (b <= int'(n));
      end
      return full;
   endfunction

   function automatic logic [HALF_IDX_W-1:0] lowest_set(input logic [HALF_SETS-1:0] v);
      logic [HALF_IDX_W-1:0] pos;
      pos = '0;
      for (int b = HALF_SETS - 1; b >= 0; b--) begin
         if (v[b]) begin
            pos = HALF_IDX_W'(b);
         end
      end
      return pos;
   endfunction

   // Index of the last subset of k sets, that is 2^k - 1.
   function automatic logic [HALF_SETS-1:0] last_index(input logic [HALF_CNT_W-1:0] k);
      logic [HALF_SZ_W-1:0] size;
      size = HALF_SZ_W'(1) << k;
      return HALF_SETS'(size - HALF_SZ_W'(1));
   endfunction

endpackage

[rtl/core/scc_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module scc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/core/subset_cover_counter_top.sv]
// ----------------------------------------------------------------------------
// Subset cover counter
// Loads a family of sets one element id per item, then counts the subsets
// whose union is exactly the elements 1..n and returns that count.
// ----------------------------------------------------------------------------
// The req channel takes one item per cycle while loading. Each item may add
// an element to the set being built; tuser bit 1 closes that set and tlast
// marks the final item of a family. The csr channel writes n, the number of
// elements to cover, and is always ready.
// After the final item the loader stops for the count. The sets are split
// into a low half of kl sets and a high half of kh sets, and the two union
// tables are built with a read and a write state per entry. The count then
// reads and checks each low union in turn; for each low union that stays
// inside the cover mask it reads every high union from the table RAM, one
// per cycle, and the EMIT state places the result in the rsp output register.
// The rsp item is held until taken; the next family may load meanwhile, and
// its own result waits in the sequencer until the register is free.
// Reset clears the loader and the sequencer and sets n to 1; the RAMs keep
// their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module subset_cover_counter_top (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: element_id
   input  logic [scc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: has_element, last_of_set
   input  logic [scc_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: cover_count
   output logic [scc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // tuser: too_many_sets
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [scc_pkg::ID_W-1:0]          csr_data,
   input  logic                              csr_valid,
   output logic                              csr_ready
);

   import scc_pkg::*;

   state_type               state_ff, state_in;
   logic [ID_W-1:0]         element_count_ff;
   logic [MASK_W-1:0]       building_ff, building_in;
   logic [SET_CNT_W-1:0]    set_total_ff, set_total_in;
   logic                    overflow_ff, overflow_in;
   logic                    half_ff, half_in;
   logic [HALF_SETS-1:0]    idx_ff, idx_in;
   logic [HALF_SETS-1:0]    jdx_ff, jdx_in;
   logic [HALF_SETS-1:0]    low_last_ff, low_last_in;
   logic [HALF_SETS-1:0]    high_last_ff, high_last_in;
   logic [SET_IDX_W-1:0]    high_base_ff, high_base_in;
   logic [MASK_W-1:0]       full_ff, full_in;
   logic [MASK_W-1:0]       a_ff, a_in;
   logic                    b_vld_ff, b_vld_in;
   logic [COUNT_W-1:0]      tally_ff, tally_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_flag_ff, rsp_flag_in;

   logic                    req_fire;
   logic                    close_set;
   logic                    store_set;
   logic [MASK_W-1:0]       mask_next;
   logic [SET_CNT_W-1:0]    total_next;
   logic [HALF_CNT_W-1:0]   k_low;
   logic [HALF_CNT_W-1:0]   k_high;
   logic [HALF_SETS-1:0]    cur_last;
   logic                    emit_load;
   logic                    a_outside;

   logic                    mask_wr_en;
   logic [SET_IDX_W-1:0]    mask_wr_addr;
   logic [SET_IDX_W-1:0]    mask_rd_addr;
   logic [MASK_W-1:0]       mask_rd_data;
   logic                    tab_wr_en;
   logic [TAB_AW-1:0]       tab_wr_addr;
   logic [MASK_W-1:0]       tab_wr_data;
   logic [TAB_AW-1:0]       tab_rd_addr;
   logic [MASK_W-1:0]       tab_rd_data;

   scc_ram #(
      .WIDTH (MASK_W),
      .DEPTH (MAX_SETS)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_wr_en),
      .wr_addr (mask_wr_addr),
      .wr_data (mask_next),
      .rd_addr (mask_rd_addr),
      .rd_data (mask_rd_data)
   );

   scc_ram #(
      .WIDTH (MASK_W),
      .DEPTH (TAB_DEPTH)
   ) u_union_ram (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_data),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rd_data)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_count_ff);
   assign rsp_tuser  = rsp_flag_ff;

   assign req_fire   = req_tvalid && req_tready;
   assign close_set  = req_tuser[SET_END_BIT];
   assign store_set  = close_set && (set_total_ff < SET_CNT_W'(MAX_SETS));
   assign mask_next  = building_ff
                     | (req_tuser[HAS_BIT] ? (MASK_W'(1) << req_tdata[ID_W-1:0]) : '0);
   assign total_next = set_total_ff + SET_CNT_W'(store_set);
   assign k_low      = HALF_CNT_W'(total_next >> 1);
   assign k_high     = HALF_CNT_W'(total_next - (total_next >> 1));
   assign cur_last   = half_ff ? high_last_ff : low_last_ff;
   assign emit_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign a_outside  = (tab_rd_data & ~full_ff) != '0;

   assign mask_wr_en   = req_fire && store_set;
   assign mask_wr_addr = set_total_ff[SET_IDX_W-1:0];
   assign mask_rd_addr = (half_ff ? high_base_ff : '0) + SET_IDX_W'(lowest_set(idx_ff));

   assign tab_wr_en   = (state_ff == ST_BUILD_WR);
   assign tab_wr_addr = {half_ff, idx_ff};
   assign tab_wr_data = (idx_ff == '0) ? '0 : (tab_rd_data | mask_rd_data);

   always_comb begin
      case (state_ff)
         ST_BUILD_RD: tab_rd_addr = {half_ff, idx_ff & (idx_ff - 1'b1)};
         ST_A_RD:     tab_rd_addr = {1'b0, idx_ff};
         ST_B_SCAN:   tab_rd_addr = {1'b1, jdx_ff};
         default:     tab_rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_tlast) begin
               state_in = ST_BUILD_RD;
            end
         end
         ST_BUILD_RD: begin
            state_in = ST_BUILD_WR;
         end
         ST_BUILD_WR: begin
            if (idx_ff == cur_last && half_ff) begin
               state_in = ST_A_RD;
            end else begin
               state_in = ST_BUILD_RD;
            end
         end
         ST_A_RD: begin
            state_in = ST_A_CHECK;
         end
         ST_A_CHECK: begin
            if (!a_outside) begin
               state_in = ST_B_SCAN;
            end else if (idx_ff == low_last_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_A_RD;
            end
         end
         ST_B_SCAN: begin
            if (jdx_ff == high_last_ff) begin
               state_in = ST_B_DRAIN;
            end
         end
         ST_B_DRAIN: begin
            if (idx_ff == low_last_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_A_RD;
            end
         end
         ST_EMIT: begin
            if (emit_load) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      building_in  = building_ff;
      set_total_in = set_total_ff;
      overflow_in  = overflow_ff;
      half_in      = half_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      low_last_in  = low_last_ff;
      high_last_in = high_last_ff;
      high_base_in = high_base_ff;
      full_in      = full_ff;
      a_in         = a_ff;
      b_vld_in     = (state_ff == ST_B_SCAN);
      tally_in     = tally_ff;
      rsp_count_in = rsp_count_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (b_vld_ff && ((a_ff | tab_rd_data) == full_ff) && (tally_ff != COUNT_MAX)) begin
         tally_in = tally_ff + 1'b1;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               building_in  = (close_set || req_tlast) ? '0 : mask_next;
               set_total_in = total_next;
               overflow_in  = overflow_ff || (close_set && !store_set);
               if (req_tlast) begin
                  set_total_in = '0;
                  half_in      = 1'b0;
                  idx_in       = '0;
                  low_last_in  = last_index(k_low);
                  high_last_in = last_index(k_high);
                  high_base_in = SET_IDX_W'(total_next >> 1);
                  full_in      = full_mask(element_count_ff);
                  tally_in     = '0;
               end
            end
         end
         ST_BUILD_WR: begin
            if (idx_ff == cur_last) begin
               half_in = 1'b1;
               idx_in  = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_A_CHECK: begin
            a_in   = tab_rd_data;
            jdx_in = '0;
            if (a_outside) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_B_SCAN: begin
            jdx_in = jdx_ff + 1'b1;
         end
         ST_B_DRAIN: begin
            idx_in = idx_ff + 1'b1;
         end
         ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = tally_ff;
               rsp_flag_in  = overflow_ff;
               overflow_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_LOAD;
         element_count_ff <= ID_W'(1);
         building_ff      <= '0;
         set_total_ff     <= '0;
         overflow_ff      <= 1'b0;
         half_ff          <= 1'b0;
         b_vld_ff         <= 1'b0;
         tally_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         building_ff  <= building_in;
         set_total_ff <= set_total_in;
         overflow_ff  <= overflow_in;
         half_ff      <= half_in;
         b_vld_ff     <= b_vld_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            element_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      jdx_ff       <= jdx_in;
      low_last_ff  <= low_last_in;
      high_last_ff <= high_last_in;
      high_base_ff <= high_base_in;
      full_ff      <= full_in;
      a_ff         <= a_in;
      rsp_count_ff <= rsp_count_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      set_total_ff <= SET_CNT_W'(MAX_SETS))
      else $error("stored set count exceeds its capacity");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_SCAN) |-> (jdx_ff <= high_last_ff))
      else $error("high union index ran past the last subset");

   a_low_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_RD || state_ff == ST_A_CHECK || state_ff == ST_B_SCAN
       || state_ff == ST_B_DRAIN) |-> (idx_ff <= low_last_ff))
      else $error("low union index ran past the last subset");

   a_drain_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_DRAIN) |-> b_vld_ff)
      else $error("final high union read lost before its compare");

   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> (rsp_valid_ff && state_ff == ST_LOAD))
      else $error("count not handed to the output register");

endmodule

[tb/sv/subset_cover_counter_checker.sv]
// ----------------------------------------------------------------------------
// Subset cover counter checker
// Watches the request, configuration and result channels of the block. It
// keeps its own copy of the loaded sets and of n, works out the cover count
// of every family when its final item is taken, and compares each result
// item with the oldest count still due.
// ----------------------------------------------------------------------------
module subset_cover_counter_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [scc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [scc_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input  logic                              req_tlast,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [scc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [scc_pkg::ID_W-1:0]          csr_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   output int                                mismatches,
   output int                                counts_due,
   output int                                counts_checked
);

   import scc_pkg::*;

   localparam int TABLE_LEN = 1 << HALF_SETS;

   typedef struct {
      logic [COUNT_W-1:0] count;
      logic               overflow;
   } cover_result_type;

   cover_result_type cover_expected[$];
   bit [MASK_W-1:0] family_masks [MAX_SETS];
   bit [MASK_W-1:0] half_unions [2][TABLE_LEN];
   int              family_size;
   bit [MASK_W-1:0] open_mask;
   bit              sets_dropped;
   bit [ID_W-1:0]   cover_size;

   task report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   // The loaded sets are split into a lower and an upper half. Every union of
   // the upper half that stays inside the target is kept, and each union of
   // the lower half that stays inside is paired with the kept ones that
   // supply the elements it lacks.
   function automatic bit [COUNT_W-1:0] tally_covers();
      bit [MASK_W-1:0] target;
      bit [MASK_W-1:0] need;
      int              k_low;
      int              k_high;
      int              kept;
      int              h;
      int              b;
      int              i;
      int              j;
      int              base;
      int              k;
      longint unsigned hits;
      k_low  = family_size / 2;
      k_high = family_size - k_low;
      target = (cover_size == 6'd63) ? ~64'd1
                                     : (64'd1 << (int'(cover_size) + 1)) - 64'd2;
      for (h = 0; h < 2; h++) begin
         base = (h == 0) ? 0 : k_low;
         k    = (h == 0) ? k_low : k_high;
         half_unions[h][0] = '0;
         for (b = 0; b < k; b++) begin
            for (i = 0; i < (1 << b); i++) begin
               half_unions[h][i + (1 << b)] = half_unions[h][i] | family_masks[base + b];
            end
         end
      end
      kept = 0;
      for (j = 0; j < (1 << k_high); j++) begin
         if ((half_unions[1][j] & ~target) == '0) begin
            half_unions[1][kept] = half_unions[1][j];
            kept++;
         end
      end
      hits = 0;
      for (i = 0; i < (1 << k_low); i++) begin
         if ((half_unions[0][i] & ~target) == '0) begin
            need = target & ~half_unions[0][i];
            for (j = 0; j < kept; j++) begin
               if ((half_unions[1][j] & need) == need) begin
                  hits++;
               end
            end
         end
      end
      if (hits > COUNT_MAX) begin
         hits = COUNT_MAX;
      end
      return hits[COUNT_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      cover_result_type due;
      if (reset) begin
         cover_expected.delete();
         family_size    = 0;
         open_mask      = '0;
         sets_dropped   = 1'b0;
         cover_size     = ID_W'(1);
         mismatches     = 0;
         counts_due     = 0;
         counts_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            cover_size = csr_data;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[HAS_BIT]) begin
               open_mask[req_tdata[ID_W-1:0]] = 1'b1;
            end
            if (req_tuser[SET_END_BIT]) begin
               if (family_size < MAX_SETS) begin
                  family_masks[family_size] = open_mask;
                  family_size++;
               end else begin
                  sets_dropped = 1'b1;
               end
               open_mask = '0;
            end
            if (req_tlast) begin
               due.count      = tally_covers();
               due.overflow   = sets_dropped;
               cover_expected = {cover_expected, due};
               family_size    = 0;
               open_mask      = '0;
               sets_dropped   = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cover_expected.size() == 0) begin
               report_mismatch("result item arrived with no count due");
            end else begin
               due = cover_expected.pop_front();
               if (rsp_tdata[COUNT_W-1:0] !== due.count) begin
                  report_mismatch($sformatf("cover_count %0d, expected %0d",
                                            rsp_tdata[COUNT_W-1:0], due.count));
               end
               if (rsp_tuser !== due.overflow) begin
                  report_mismatch($sformatf("too_many_sets %0b, expected %0b",
                                            rsp_tuser, due.overflow));
               end
               counts_checked++;
            end
         end
         counts_due = cover_expected.size();
      end
   end

endmodule

[tb/sv/subset_cover_counter_top_test.sv]
// ----------------------------------------------------------------------------
// Subset cover counter testbench
// Loads families of sets into the block under a range of cover sizes: a few
// hand-picked families first, then an overflowing family with too many sets,
// a burst against a stalled result channel and many random families.
// A checker beside the block predicts and compares every count.
// ----------------------------------------------------------------------------
module subset_cover_counter_top_test;

   import scc_pkg::*;

   localparam int ITEMS_WANTED   = 1900;
   localparam int PHASE_ITEMS    = 190;
   localparam int SQUEEZE_CYCLES = 600;

   typedef struct packed {
      bit [ID_W-1:0] id;
      bit            has;
      bit            close;
      bit            fin;
   } load_step_type;

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   req_tlast;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [ID_W-1:0]        csr_data;
   logic                   csr_valid;
   logic                   csr_ready;
   int                     mismatches;
   int                     counts_due;
   int                     counts_checked;

   bit                     calm;
   bit                     gappy;
   bit                     squeeze_go;
   bit                     squeeze_done;
   int                     cover_now;
   int                     items_sent;
   int                     families_sent;
   int                     csr_writes;
   load_step_type          load_plan[$];

   subset_cover_counter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   subset_cover_counter_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Run timed out with %0d counts still due.", counts_due);
      $display("CHECKS FAILED");
      $finish;
   end

   // Result side: random stalls, one long hold when asked for, and none at
   // all once the run has calmed down.
   initial begin
      rsp_tready   = 1'b0;
      squeeze_done = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_go && !squeeze_done) begin
            rsp_tready = 1'b0;
            repeat (SQUEEZE_CYCLES) @(negedge clock);
            squeeze_done = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
   end

   task automatic offer_item(input bit [ID_W-1:0] id, input bit has, input bit close,
                             input bit fin);
      int gap;
      gap = (gappy && !calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = REQ_TDATA_W'(id);
      req_tuser  = {close, has};
      req_tlast  = fin;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic add_step(input int id, input bit has, input bit close, input bit fin);
      load_step_type step;
      step.id    = ID_W'(id);
      step.has   = has;
      step.close = close;
      step.fin   = fin;
      load_plan  = {load_plan, step};
   endtask

   task automatic mark_final();
      load_step_type step;
      step      = load_plan.pop_back();
      step.fin  = 1'b1;
      load_plan = {load_plan, step};
   endtask

   task automatic send_plan();
      foreach (load_plan[i]) begin
         offer_item(load_plan[i].id, load_plan[i].has, load_plan[i].close, load_plan[i].fin);
      end
      load_plan.delete();
      families_sent++;
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (counts_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_cover_size(input int n);
      @(negedge clock);
      csr_data  = ID_W'(n);
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      cover_now = n;
      csr_writes++;
   endtask

   task automatic send_random_family(input int most_sets);
      int sets;
      int elems;
      int top_id;
      int s;
      int e;
      top_id = (cover_now < 1) ? 1 : cover_now;
      gappy  = !calm && ($urandom_range(0, 2) != 0);
      if (most_sets > 8 && $urandom_range(0, 19) == 0) begin
         sets = $urandom_range(9, most_sets);
      end else begin
         sets = $urandom_range(0, (most_sets < 8) ? most_sets : 8);
      end
      for (s = 0; s < sets; s++) begin
         elems = $urandom_range(0, 3);
         if ($urandom_range(0, 9) == 0) begin
            add_step($urandom_range(0, 63), 1'b0, 1'b0, 1'b0);
         end
         if (elems == 0) begin
            add_step($urandom_range(0, 63), 1'b0, 1'b1, 1'b0);
         end
         for (e = 0; e < elems; e++) begin
            add_step(($urandom_range(0, 6) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(1, top_id),
                     1'b1, e == elems - 1, 1'b0);
         end
      end
      if (load_plan.size() == 0 || $urandom_range(0, 5) == 0) begin
         add_step($urandom_range(0, 63), $urandom_range(0, 1), 1'b0, 1'b1);
      end else begin
         mark_final();
      end
      send_plan();
   endtask

   // Each set of the lower half carries element 0, so only the empty lower
   // union stays inside the target and the count remains quick.
   task automatic send_overflow_family();
      int s;
      gappy = 1'b1;
      for (s = 0; s < MAX_SETS + 2; s++) begin
         if (s < MAX_SETS / 2) begin
            add_step(0, 1'b1, 1'b0, 1'b0);
         end else begin
            add_step($urandom_range(1, cover_now), 1'b1, 1'b0, 1'b0);
         end
         add_step($urandom_range(1, cover_now), 1'b1, 1'b1, 1'b0);
      end
      mark_final();
      send_plan();
   endtask

   initial begin
      int size_plan [9];
      int phase;
      int phase_end;
      size_plan     = '{2, 5, 0, 3, 62, 1, 63, 4, 7};
      reset         = 1'b1;
      req_tdata     = '0;
      req_tuser     = '0;
      req_tlast     = 1'b0;
      req_tvalid    = 1'b0;
      csr_data      = '0;
      csr_valid     = 1'b0;
      calm          = 1'b0;
      gappy         = 1'b1;
      squeeze_go    = 1'b0;
      cover_now     = 1;
      items_sent    = 0;
      families_sent = 0;
      csr_writes    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Cover size straight from reset: no sets, an unfinished last set and
      // a set that strays outside the target.
      add_step(0, 1'b0, 1'b0, 1'b1);
      send_plan();
      add_step(1, 1'b1, 1'b1, 1'b0);
      add_step(5, 1'b1, 1'b0, 1'b1);
      send_plan();
      add_step(1, 1'b1, 1'b1, 1'b0);
      add_step(1, 1'b1, 1'b0, 1'b0);
      add_step(2, 1'b1, 1'b1, 1'b1);
      send_plan();
      settle_block();

      // An empty target is met by any choice of empty sets.
      write_cover_size(0);
      add_step(0, 1'b0, 1'b1, 1'b0);
      add_step(9, 1'b0, 1'b1, 1'b0);
      add_step(0, 1'b1, 1'b1, 1'b1);
      send_plan();
      settle_block();

      write_cover_size(63);
      add_step(63, 1'b1, 1'b0, 1'b0);
      add_step(0, 1'b1, 1'b1, 1'b0);
      add_step(1, 1'b1, 1'b0, 1'b0);
      add_step(62, 1'b1, 1'b1, 1'b0);
      add_step(63, 1'b1, 1'b1, 1'b0);
      add_step(42, 1'b1, 1'b0, 1'b1);
      send_plan();
      settle_block();

      write_cover_size(62);
      add_step(62, 1'b1, 1'b1, 1'b0);
      add_step(63, 1'b1, 1'b1, 1'b1);
      send_plan();
      settle_block();

      write_cover_size(5);
      send_overflow_family();
      settle_block();

      squeeze_go = 1'b1;
      repeat (8) send_random_family(3);
      settle_block();

      phase = 0;
      while (items_sent < ITEMS_WANTED) begin
         if (items_sent >= ITEMS_WANTED - PHASE_ITEMS) begin
            calm = 1'b1;
         end
         if (phase < 9) begin
            write_cover_size(size_plan[phase]);
         end else if ($urandom_range(0, 3) == 0) begin
            write_cover_size($urandom_range(0, 63));
         end else begin
            write_cover_size($urandom_range(1, 8));
         end
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            send_random_family(14);
         end
         settle_block();
         phase++;
      end

      repeat (2000) @(negedge clock);
      $display("Loaded %0d items in %0d families under %0d cover sizes; %0d counts checked.",
               items_sent, families_sent, csr_writes, counts_checked);
      $display("The run took in empty and unfinished sets, a family of too many sets %s",
               "and a long result stall.");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/scc_pkg.sv
rtl/core/scc_ram.sv
rtl/core/subset_cover_counter_top.sv
tb/sv/subset_cover_counter_checker.sv
tb/sv/subset_cover_counter_top_test.sv
